[rtl/hpf_pkg.sv]
// Package for the hex packet framer: word types, queue entry, character constants.
// No dependencies; imported by every module of the block.
package hpf_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharHash   = 8'h23;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One queued packet step: what the back end must emit for one input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       open_pkt;
    logic       close_pkt;
    logic [7:0] csum;
  } cmd_t;

  typedef enum logic [5:0] {
    PhDollar = 6'b000001,
    PhHi     = 6'b000010,
    PhLo     = 6'b000100,
    PhHash   = 6'b001000,
    PhCkHi   = 6'b010000,
    PhCkLo   = 6'b100000
  } phase_e;

  // Lower-case ASCII hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

[rtl/hex_packet_framer_checksum.sv]
// Top level of the hex packet framer with checksum.
// Depends on hpf_pkg, hpf_front, hpf_queue, hpf_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): one payload byte per
//   word, last_byte set on the final byte of a packet.
//   Output channel (out_valid_o / out_stall_i / out_word_o): one ASCII
//   character per word. A packet reads '$', two lower-case hex characters per
//   byte, then '#' and two hex characters of the mod-256 sum of the data
//   characters. last_char marks the final character caused by one input word.
//   Throughput: one character per cycle, set by the output register, while
//   the receiver is not stalling and the queue is not empty; two characters
//   per middle byte, three for a first byte, five for a last byte, six for a
//   single-byte packet. The 4-entry command queue lets the front accept
//   bytes while the back end is still emitting earlier characters.
//   Reset: no packet open, checksum zero, queue and output register empty.
//   Receiver stall: the output word holds; once the queue fills, in_stall_o
//   rises and input is held off.

module hex_packet_framer_checksum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hpf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hpf_pkg::out_word_t out_word_o
);
  import hpf_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head;

  // Front: packet state and running checksum, one command per byte.
  hpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Decoupling queue between the two halves.
  hpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty)
  );

  // Back: character sequencer and output register.
  hpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[rtl/hpf_front.sv]
// Front end of the hex packet framer: accepts input words, tracks packet state
// and the running checksum, pushes one command per word. Depends on hpf_pkg.
module hpf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hpf_pkg::in_word_t  in_word_i,
  input  logic               q_full_i,
  output logic               push_o,
  output hpf_pkg::cmd_t      push_cmd_o
);
  import hpf_pkg::*;

  logic       in_packet_q, in_packet_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] base_sum, new_sum;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Sum restarts from zero when a packet opens.
  assign base_sum = in_packet_q ? sum_q : 8'd0;
  assign new_sum  = base_sum + hex_char(in_word_i.data_byte[7:4])
                  + hex_char(in_word_i.data_byte[3:0]);

  always_comb begin
    in_packet_d = in_packet_q;
    sum_d       = sum_q;
    if (accept) begin
      if (in_word_i.last_byte) begin
        in_packet_d = 1'b0;
        sum_d       = 8'd0;
      end else begin
        in_packet_d = 1'b1;
        sum_d       = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      sum_q       <= 8'd0;
    end else begin
      in_packet_q <= in_packet_d;
      sum_q       <= sum_d;
    end
  end

  assign push_o               = accept;
  assign push_cmd_o.data_byte = in_word_i.data_byte;
  assign push_cmd_o.open_pkt  = !in_packet_q;
  assign push_cmd_o.close_pkt = in_word_i.last_byte;
  assign push_cmd_o.csum      = new_sum;

endmodule

[rtl/hpf_queue.sv]
// Small register queue of commands between front and back end.
// Depends on hpf_pkg.
module hpf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hpf_pkg::cmd_t  push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output hpf_pkg::cmd_t  head_o,
  output logic           empty_o
);
  import hpf_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QueueCntW'(QueueDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

[rtl/hpf_back.sv]
// Back end of the hex packet framer (needs hpf_pkg): walks each queued command
// through its characters, one per cycle unless stalled, to the output register.
module hpf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  hpf_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hpf_pkg::out_word_t out_word_o
);
  import hpf_pkg::*;

  logic      active_q, active_d;
  phase_e    phase_q, phase_d, cur_phase, nxt_phase;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      load, emit, final_char;
  logic [7:0] ch;

  // Output register can take a new word when empty or being drained.
  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && !q_empty_i;

  assign cur_phase = active_q ? phase_q : (head_i.open_pkt ? PhDollar : PhHi);

  always_comb begin
    ch         = 8'd0;
    nxt_phase  = PhHi;
    final_char = 1'b0;
    case (cur_phase)
      PhDollar: begin
        ch        = CharDollar;
        nxt_phase = PhHi;
      end
      PhHi: begin
        ch        = hex_char(head_i.data_byte[7:4]);
        nxt_phase = PhLo;
      end
      PhLo: begin
        ch         = hex_char(head_i.data_byte[3:0]);
        nxt_phase  = PhHash;
        final_char = !head_i.close_pkt;
      end
      PhHash: begin
        ch        = CharHash;
        nxt_phase = PhCkHi;
      end
      PhCkHi: begin
        ch        = hex_char(head_i.csum[7:4]);
        nxt_phase = PhCkLo;
      end
      PhCkLo: begin
        ch         = hex_char(head_i.csum[3:0]);
        final_char = 1'b1;
      end
      default: begin
        ch = 8'd0;
      end
    endcase
  end

  assign pop_o = emit && final_char;

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    if (emit) begin
      active_d = !final_char;
      phase_d  = nxt_phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      phase_q     <= PhHi;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      if (load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q.out_char  <= ch;
      out_word_q.last_char <= final_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> $onehot(phase_q))
    else $error("phase not one-hot");
  a_pop_when_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (emit && !q_empty_i))
    else $error("pop without emitted character");
  a_active_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !q_empty_i)
    else $error("mid-sequence with empty queue");

endmodule

[dv/tb.sv]
// Self-checking testbench for hex_packet_framer_checksum: framed ASCII output against a
// packet model kept in the bench. Depends on hpf_pkg and the framer RTL only.
module tb;

  import hpf_pkg::*;

  // Receiver stall behavior, switched to a random mode when its span runs out.
  typedef enum logic [1:0] {
    RxFree,      // never stalls
    RxLight,     // stalls with a chance of about one in four
    RxHeavy,     // stalls with a chance of about three in four
    RxPeriodic   // stalls when the cycle count is a multiple of stall_period
  } rx_mode_e;

  // A pending input word; drain asks the sender to hold off until the
  // framer has delivered every character it owes before this word goes out.
  typedef struct packed {
    logic     drain;
    in_word_t w;
  } stim_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  stim_t     stim_q[$];   // words still to be offered
  out_word_t char_q[$];   // characters the framer still owes, oldest first

  // Packet model state.
  logic       pkt_open = 1'b0;
  logic [7:0] pkt_sum  = 8'h00;

  // Sender burst/gap control.
  logic       in_fire    = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 0;

  // Receiver pattern control.
  rx_mode_e   rx_mode      = RxFree;
  int         rx_span      = 0;
  int         stall_period = 3;
  int         rx_cycle     = 0;

  int         err_cnt      = 0;
  int         chars_seen   = 0;
  int         bytes_sent   = 0;
  int         pkts_sent    = 0;
  int         stall_cycles = 0;
  int         drain_waits  = 0;

  hex_packet_framer_checksum i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Packet model
  // ---------------------------------------------------------------------

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    string digits = "0123456789abcdef";
    return digits[nib];
  endfunction

  // Works out the characters one accepted payload word causes and queues
  // them. '$' only when no packet is open; the checksum covers the hex
  // data characters only and wraps mod 256.
  function automatic void frame_byte(input in_word_t w);
    out_word_t  seq[$];
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    hi_c = ascii_hex(w.data_byte[7:4]);
    lo_c = ascii_hex(w.data_byte[3:0]);
    if (!pkt_open) begin
      seq.push_back({CharDollar, 1'b0});
      pkt_sum  = 8'h00;
      pkt_open = 1'b1;
    end
    seq.push_back({hi_c, 1'b0});
    seq.push_back({lo_c, 1'b0});
    pkt_sum = pkt_sum + hi_c + lo_c;
    if (w.last_byte) begin
      seq.push_back({CharHash, 1'b0});
      seq.push_back({ascii_hex(pkt_sum[7:4]), 1'b0});
      seq.push_back({ascii_hex(pkt_sum[3:0]), 1'b0});
      pkt_open = 1'b0;
      pkt_sum  = 8'h00;
    end
    // last_char flags the final character of this word only.
    seq[seq.size() - 1].last_char = 1'b1;
    foreach (seq[k]) char_q.push_back(seq[k]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The output check
  // runs before the input prediction; a character can never come out at
  // the same edge that accepts the word causing it.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_stall_i) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        chars_seen++;
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_word_o.out_char, out_word_o.last_char));
        end else begin
          if (out_word_o.out_char !== char_q[0].out_char)
            report_mismatch($sformatf("out_char got 0x%02h want 0x%02h",
                                      out_word_o.out_char, char_q[0].out_char));
          if (out_word_o.last_char !== char_q[0].last_char)
            report_mismatch($sformatf("last_char got %0b want %0b (char 0x%02h)",
                                      out_word_o.last_char, char_q[0].last_char,
                                      char_q[0].out_char));
          void'(char_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        frame_byte(in_word_i);
        bytes_sent++;
        if (in_word_i.last_byte) pkts_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offers words in bursts with random gaps, changes at the
  // falling edge. A word flagged drain waits until char_q is empty.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic     nxt_valid;
    in_word_t nxt_word;
    nxt_valid = in_valid_i;
    nxt_word  = in_word_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
      nxt_word  = '0;
    end else begin
      if (in_fire) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          if (stim_q[0].drain && char_q.size() != 0) begin
            // hold off: framer still flushing the previous packet
          end else begin
            if (stim_q[0].drain) drain_waits++;
            nxt_valid = 1'b1;
            nxt_word  = stim_q[0].w;
            void'(stim_q.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 15);
              case ($urandom_range(0, 7))
                0, 1:    gap_left = 0;
                7:       gap_left = $urandom_range(10, 25);
                default: gap_left = $urandom_range(1, 6);
              endcase
            end
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_word_i  <= nxt_word;
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern of its own, independent of the sender.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic stall_now;
    stall_now = 1'b0;
    if (rst_ni) begin
      if (rx_span == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_span      = $urandom_range(8, 60);
        stall_period = $urandom_range(2, 5);
      end else begin
        rx_span--;
      end
      rx_cycle++;
      case (rx_mode)
        RxFree:     stall_now = 1'b0;
        RxLight:    stall_now = ($urandom_range(0, 3) == 0);
        RxHeavy:    stall_now = ($urandom_range(0, 3) != 0);
        RxPeriodic: stall_now = (rx_cycle % stall_period == 0);
        default:    stall_now = 1'b0;
      endcase
    end
    out_stall_i <= stall_now;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] data, input logic last, input logic drain);
    stim_t s;
    s.drain       = drain;
    s.w.data_byte = data;
    s.w.last_byte = last;
    stim_q.push_back(s);
  endtask

  // Random-content packet of len bytes; only the final one carries last.
  task automatic add_packet(input int len, input logic drain);
    for (int k = 0; k < len; k++)
      add_byte(8'($urandom_range(0, 255)), (k == len - 1), drain && (k == 0));
  endtask

  initial begin
    int queued;
    int len;

    // Directed part.
    // Single-byte packets at both data extremes: '$', hex pair, '#', sum.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hff, 1'b1, 1'b0);
    // Digit/letter boundary in both nibbles; first, middle and last bytes.
    add_byte(8'h09, 1'b0, 1'b0);
    add_byte(8'h0a, 1'b0, 1'b0);
    add_byte(8'h90, 1'b0, 1'b0);
    add_byte(8'ha0, 1'b0, 1'b0);
    add_byte(8'h5a, 1'b1, 1'b0);
    // Run of 0xff: 'f'+'f' = 0xcc per byte, so the checksum wraps.
    for (int k = 0; k < 6; k++) add_byte(8'hff, (k == 5), 1'b0);
    // Lowest and highest data bit alone, then a packet opened right after a close.
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);
    // Sender waits for a fully drained framer before this one.
    add_byte(8'h7f, 1'b1, 1'b1);

    // Random part: mostly short packets, some single-byte, a few long.
    queued = 0;
    while (queued < 135) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = 1;
        9:       len = $urandom_range(15, 30);
        default: len = $urandom_range(2, 8);
      endcase
      add_packet(len, (queued == 0) || ($urandom_range(0, 11) == 0));
      queued += len;
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last word to be taken, then for the framer to drain;
    // then a short tail to catch any stray characters.
    while (stim_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d payload bytes in %0d packets; checked %0d characters.",
             bytes_sent, pkts_sent, chars_seen);
    $display("Receiver stalled %0d cycles; sender drained the framer %0d times.",
             stall_cycles, drain_waits);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Run limit reached with %0d characters outstanding.", char_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
